// ===== rtl/core/first_fit_block_allocator_unit_defines.svh =====
// assertion macros for the first-fit block allocator
// no dependencies; included by files that carry concurrent checks
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FFBA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ffba_pkg.sv =====
// shared types, widths and codes for the first-fit block allocator
// no dependencies
package ffba_pkg;

  localparam int LEN_W          = 13;
  localparam int OFS_W          = 12;
  localparam int NEED_W         = 14;
  localparam int STATUS_W       = 2;
  localparam int HDR_BYTES      = 8;
  localparam int MIN_POOL       = 16;
  localparam int POOL_BYTES_DEF = 4096;
  localparam int POOL_RST_MAX   = 4096;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // one block header as stored
  typedef struct packed {
    logic             taken;
    logic [LEN_W-1:0] len;
  } hdr_t;

  // header store port control
  typedef struct packed {
    logic rd;
    logic wr;
  } hdr_ctl_t;

endpackage

// ===== rtl/core/ffba_req_if.sv =====
// request channel: command, request size and payload offset
// depends on ffba_pkg
interface ffba_req_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [LEN_W-1:0]  request_bytes;
  logic [OFS_W-1:0]  payload_offset;

  modport source (output valid, command, request_bytes, payload_offset, input ready);
  modport sink (input valid, command, request_bytes, payload_offset, output ready);
endinterface

// ===== rtl/core/ffba_rsp_if.sv =====
// response channel: status and granted payload offset
// depends on ffba_pkg
interface ffba_rsp_if import ffba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFS_W-1:0]    granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink (input valid, status, granted_offset, output ready);
endinterface

// ===== rtl/core/ffba_alu.sv =====
// shared add / subtract unit used by the allocator sequencer
// depends on ffba_pkg
module ffba_alu import ffba_pkg::*; #(
  parameter int W = NEED_W
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] y,
  output logic         borrow
);

  logic [W:0] r;

  always_comb begin
    case (op)
      ALU_ADD: r = {1'b0, a} + {1'b0, b};
      ALU_SUB: r = {1'b0, a} - {1'b0, b};
      default: r = '0;
    endcase
  end

  assign y      = r[W-1:0];
  assign borrow = r[W];

endmodule

// ===== rtl/core/ffba_hdr_mem.sv =====
// block header store, one port, registered read data
// depends on ffba_pkg
module ffba_hdr_mem import ffba_pkg::*; #(
  parameter int DEPTH = POOL_BYTES_DEF,
  parameter int AW    = $clog2(POOL_BYTES_DEF)
) (
  input  logic          clk,
  input  hdr_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  hdr_t          wdata,
  output hdr_t          rdata
);

  hdr_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/first_fit_block_allocator_unit.sv =====
// first-fit block allocator with coalescing; depends on ffba_pkg, ffba_req_if,
// ffba_rsp_if, ffba_alu, ffba_hdr_mem and the assertion macro header
// req carries one transaction per command: allocate (command 0, request_bytes)
// or release (command 1, payload_offset); rsp returns status and granted_offset
// cfg_wr_en / cfg_wr_data write pool_size (clamped to 16..POOL_BYTES)
// each command walks the header chain from offset 0, one header per store read;
// each visited header is read, checked and advanced past; a release offset out of
// range answers without a walk, and a granted, released or failed command answers
// once its walk and any header writes are done
// one command at a time: req.ready is high only while the sequencer is idle
// the result sits in an output register; a stalled rsp holds it, and a finished
// command waits in its final state until the register frees up
// after reset and after every pool_size write a clearing pass writes every header
// (entry 0 gets one free block of pool_size); req.ready stays low during the pass,
// and a pool_size write restarts it
`include "first_fit_block_allocator_unit_defines.svh"

module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int POOL_BYTES = POOL_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  ffba_req_if.sink         req,
  ffba_rsp_if.source       rsp
);

  localparam int AW = $clog2(POOL_BYTES);
  // walk pointer width: covers the store and one header length past it
  localparam int PW = (AW + 1 > NEED_W) ? AW + 1 : NEED_W;
  localparam int POOL_RST = (POOL_BYTES < POOL_RST_MAX) ? POOL_BYTES : POOL_RST_MAX;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RD    = 13'b0000000000100,
    S_CHK   = 13'b0000000001000,
    S_NEXT  = 13'b0000000010000,
    S_SPLIT = 13'b0000000100000,
    S_WR2   = 13'b0000001000000,
    S_FREE  = 13'b0000010000000,
    S_NRD   = 13'b0000100000000,
    S_NCHK  = 13'b0001000000000,
    S_PRD   = 13'b0010000000000,
    S_PCHK  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t               state;
  logic [AW-1:0]        clr_addr;
  logic [LEN_W-1:0]     pool_size;
  logic [LEN_W-1:0]     pool_size_next;

  // per-command working registers
  logic                 cmd;
  logic [NEED_W-1:0]    need;
  logic [OFS_W-1:0]     target;
  logic [PW-1:0]        at;
  logic [PW-1:0]        prev_at;
  logic                 have_before;
  logic [PW-1:0]        nxt;
  logic [PW-1:0]        spl_at;
  logic [LEN_W-1:0]     cur_len;
  logic [LEN_W-1:0]     rest;
  logic [STATUS_W-1:0]  item_status;
  logic [OFS_W-1:0]     item_granted;

  // output register
  logic                 res_valid;
  logic [STATUS_W-1:0]  res_status;
  logic [OFS_W-1:0]     res_granted;
  logic                 res_load;

  // shared unit and header store wiring
  alu_op_t              alu_op;
  logic [PW-1:0]        alu_a;
  logic [PW-1:0]        alu_b;
  logic [PW-1:0]        alu_y;
  logic                 alu_borrow;
  hdr_ctl_t             mem_ctl;
  logic [AW-1:0]        mem_addr;
  hdr_t                 mem_wdata;
  hdr_t                 mem_rdata;

  logic                 walk_ok;
  logic                 next_ok;
  logic                 do_split;
  logic [STATUS_W-1:0]  fail_code;
  logic [PW-1:0]        cfg_ext;

  ffba_alu #(.W(PW)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  ffba_hdr_mem #(.DEPTH(POOL_BYTES), .AW(AW)) u_hdr_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // clamp the written pool size to the supported range
  always_comb begin
    cfg_ext = PW'(cfg_wr_data);
    if (cfg_wr_data < LEN_W'(MIN_POOL)) begin
      pool_size_next = LEN_W'(MIN_POOL);
    end else if (cfg_ext > PW'(POOL_BYTES)) begin
      pool_size_next = LEN_W'(POOL_BYTES);
    end else begin
      pool_size_next = cfg_wr_data;
    end
  end

  // walk may continue: inside the pool, inside the store, not past the release target
  assign walk_ok = (at < PW'(pool_size)) && (at < PW'(POOL_BYTES)) &&
                   ((cmd == CMD_ALLOC) || (at <= PW'(target)));
  // successor header far enough from the pool end to be merged
  assign next_ok = ((nxt + PW'(HDR_BYTES)) < PW'(pool_size)) && (nxt < PW'(POOL_BYTES));
  // split only when the remainder holds more than a bare header
  assign do_split  = (rest > LEN_W'(HDR_BYTES)) && (alu_y < PW'(POOL_BYTES));
  assign fail_code = (cmd == CMD_ALLOC) ? ST_NOMEM : ST_BAD;
  // finished command moves into the output register this cycle
  assign res_load  = (state == S_FIN) && !cfg_wr_en && (!res_valid || rsp.ready);

  assign req.ready          = (state == S_IDLE) && !cfg_wr_en;
  assign rsp.valid          = res_valid;
  assign rsp.status         = res_status;
  assign rsp.granted_offset = res_granted;

  // operand selection and store access per sequencer step
  always_comb begin
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    mem_ctl   = '0;
    mem_addr  = '0;
    mem_wdata = '0;
    case (state)
      S_CLR: begin
        mem_ctl.wr = 1'b1;
        mem_addr   = clr_addr;
        if (clr_addr == '0) begin
          mem_wdata.len = pool_size;
        end
      end
      S_IDLE: begin
        // need = request + header
        alu_a = PW'(req.request_bytes);
        alu_b = PW'(HDR_BYTES);
      end
      S_RD: begin
        if (walk_ok) begin
          mem_ctl.rd = 1'b1;
          mem_addr   = at[AW-1:0];
        end
      end
      S_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = PW'(mem_rdata.len);
        alu_b  = PW'(need);
      end
      S_NEXT: begin
        alu_a = at;
        alu_b = PW'(cur_len);
      end
      S_SPLIT: begin
        alu_a           = at;
        alu_b           = PW'(need);
        mem_ctl.wr      = 1'b1;
        mem_addr        = at[AW-1:0];
        mem_wdata.taken = 1'b1;
        mem_wdata.len   = do_split ? need[LEN_W-1:0] : cur_len;
      end
      S_WR2: begin
        mem_ctl.wr    = 1'b1;
        mem_addr      = spl_at[AW-1:0];
        mem_wdata.len = rest;
      end
      S_FREE: begin
        alu_a         = at;
        alu_b         = PW'(cur_len);
        mem_ctl.wr    = 1'b1;
        mem_addr      = at[AW-1:0];
        mem_wdata.len = cur_len;
      end
      S_NRD: begin
        if (next_ok) begin
          mem_ctl.rd = 1'b1;
          mem_addr   = nxt[AW-1:0];
        end
      end
      S_NCHK: begin
        // absorb a free successor
        alu_a = PW'(cur_len);
        alu_b = PW'(mem_rdata.len);
        if (!mem_rdata.taken) begin
          mem_ctl.wr    = 1'b1;
          mem_addr      = at[AW-1:0];
          mem_wdata.len = alu_y[LEN_W-1:0];
        end
      end
      S_PRD: begin
        if (have_before) begin
          mem_ctl.rd = 1'b1;
          mem_addr   = prev_at[AW-1:0];
        end
      end
      S_PCHK: begin
        // fold into a free predecessor
        alu_a = PW'(mem_rdata.len);
        alu_b = PW'(cur_len);
        if (!mem_rdata.taken) begin
          mem_ctl.wr    = 1'b1;
          mem_addr      = prev_at[AW-1:0];
          mem_wdata.len = alu_y[LEN_W-1:0];
        end
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      pool_size <= LEN_W'(POOL_RST);
      res_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        // new pool size: rebuild the chain from scratch
        pool_size <= pool_size_next;
        clr_addr  <= '0;
        state     <= S_CLR;
      end else begin
        case (state)
          S_CLR: begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == AW'(POOL_BYTES - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (req.valid) begin
              cmd          <= req.command;
              need         <= alu_y[NEED_W-1:0];
              target       <= req.payload_offset - OFS_W'(HDR_BYTES);
              at           <= '0;
              have_before  <= 1'b0;
              item_granted <= '0;
              if ((req.command == CMD_FREE) &&
                  ((req.payload_offset < OFS_W'(HDR_BYTES)) ||
                   (LEN_W'(req.payload_offset) >= pool_size))) begin
                item_status <= ST_BAD;
                state       <= S_FIN;
              end else begin
                item_status <= ST_OK;
                state       <= S_RD;
              end
            end
          end
          S_RD: begin
            if (walk_ok) begin
              state <= S_CHK;
            end else begin
              item_status <= fail_code;
              state       <= S_FIN;
            end
          end
          S_CHK: begin
            cur_len <= mem_rdata.len;
            rest    <= alu_y[LEN_W-1:0];
            if (mem_rdata.len == '0) begin
              // broken chain ends the walk
              item_status <= fail_code;
              state       <= S_FIN;
            end else if (cmd == CMD_ALLOC) begin
              if (!mem_rdata.taken && !alu_borrow) begin
                state <= S_SPLIT;
              end else begin
                state <= S_NEXT;
              end
            end else if (at == PW'(target)) begin
              if (mem_rdata.taken) begin
                state <= S_FREE;
              end else begin
                item_status <= ST_BAD;
                state       <= S_FIN;
              end
            end else begin
              state <= S_NEXT;
            end
          end
          S_NEXT: begin
            at <= alu_y;
            if (cmd == CMD_FREE) begin
              prev_at     <= at;
              have_before <= 1'b1;
            end
            state <= S_RD;
          end
          S_SPLIT: begin
            item_granted <= at[OFS_W-1:0] + OFS_W'(HDR_BYTES);
            spl_at       <= alu_y;
            state        <= do_split ? S_WR2 : S_FIN;
          end
          S_WR2: begin
            state <= S_FIN;
          end
          S_FREE: begin
            nxt   <= alu_y;
            state <= S_NRD;
          end
          S_NRD: begin
            state <= next_ok ? S_NCHK : S_PRD;
          end
          S_NCHK: begin
            if (!mem_rdata.taken) begin
              cur_len <= alu_y[LEN_W-1:0];
            end
            state <= S_PRD;
          end
          S_PRD: begin
            state <= have_before ? S_PCHK : S_FIN;
          end
          S_PCHK: begin
            state <= S_FIN;
          end
          S_FIN: begin
            if (res_load) begin
              res_valid   <= 1'b1;
              res_status  <= item_status;
              res_granted <= item_granted;
              state       <= S_IDLE;
            end
          end
          default: begin
            clr_addr <= '0;
            state    <= S_CLR;
          end
        endcase
      end
    end
  end

  `FFBA_ASSERT_IMPLIES(a_no_write_idle, clk, rst, state == S_IDLE, !mem_ctl.wr,
                       "header write while idle")
  `FFBA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, req.valid && req.ready,
                    state != S_IDLE, "accepted transaction did not start")
  `FFBA_ASSERT_IMPLIES(a_fail_no_offset, clk, rst, rsp.valid && (rsp.status != ST_OK),
                       rsp.granted_offset == '0, "failed transaction carries an offset")
  `FFBA_ASSERT_NEXT(a_cfg_restarts_clear, clk, rst, cfg_wr_en,
                    (state == S_CLR) && (clr_addr == '0), "pool size write did not restart clearing")

endmodule
